/* rtl/core/assert_macros.svh */
// Assertion macros used by the spectrum block controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define FMS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define FMS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define FMS_ASSERT(lbl, clk, rstn, prop, msg)
`define FMS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/core/fms_pkg.sv */
// Shared types, constants and twiddle lookup for the magnitude spectrum block.
package fms_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 22;
  localparam int BIN_W      = 6;
  localparam int CC_W       = 4;
  localparam int PHASE_W    = 3;
  localparam int TW_IDX_W   = 6;
  localparam int TW_W       = 32;
  localparam int PROD_W     = SAMPLE_W + TW_W;
  localparam int ACC_W      = 54;
  localparam int RND_W      = 23;
  localparam int RAD_W      = 44;
  localparam int SQRT_STEPS = 22;
  localparam int SQRT_CNT_W = 5;
  localparam int TW_FRAC    = 30;
  localparam int MAX_CHANNELS = 8;

  // Quarter-wave cosine, Q2.30, 17 entries.
  localparam logic signed [TW_W-1:0] QUARTER_COS [17] = '{
    32'sd1073741824, 32'sd1068571464, 32'sd1053110176, 32'sd1027506862,
    32'sd992008094,  32'sd946955747,  32'sd892783698,  32'sd830013654,
    32'sd759250125,  32'sd681174602,  32'sd596538995,  32'sd506158392,
    32'sd410903207,  32'sd311690799,  32'sd209476638,  32'sd105245103,
    32'sd0
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_SQUARE,
    S_SUM,
    S_SQRT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic                wr_en;
    logic                acc_clear;
    logic                mac_issue;
    logic [TW_IDX_W-1:0] tw_idx;
    logic                do_round;
    logic                do_square;
    logic                do_sum;
    logic                sqrt_step;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } status_t;

  // cos(2 pi m / 64) in Q2.30
  function automatic logic signed [TW_W-1:0] cos64(input logic [TW_IDX_W-1:0] m);
    logic [TW_IDX_W:0] mw;
    logic signed [TW_W-1:0] r;
    mw = {1'b0, m};
    if (mw <= 7'd16) begin
      r = QUARTER_COS[mw[4:0]];
    end else if (mw <= 7'd32) begin
      r = -QUARTER_COS[5'(7'd32 - mw)];
    end else if (mw <= 7'd48) begin
      r = -QUARTER_COS[5'(mw - 7'd32)];
    end else begin
      r = QUARTER_COS[5'(7'd64 - mw)];
    end
    return r;
  endfunction

  // sin(2 pi m / 64) in Q2.30
  function automatic logic signed [TW_W-1:0] sin64(input logic [TW_IDX_W-1:0] m);
    return cos64(m + TW_IDX_W'(48));
  endfunction

endpackage

/* rtl/core/fms_ctrl.sv */
// Controller: frame collection, bin sequencing and the per-bin step sequence.
`include "assert_macros.svh"
module fms_ctrl #(
  parameter int POINTS = 64,
  parameter int IDX_W  = $clog2(POINTS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_we_i,
  input  logic [fms_pkg::CC_W-1:0] cfg_wdata_i,
  output fms_pkg::cmd_t           cmd_o,
  input  fms_pkg::status_t        status_i,
  output logic [IDX_W:0]          wr_addr_o,
  output logic [IDX_W:0]          rd_addr_o,
  output logic                    result_valid_o,
  output logic [fms_pkg::BIN_W-1:0] bin_index_o,
  output logic                    last_bin_o
);
  import fms_pkg::*;

  localparam int STRIDE = 64 / POINTS;

  state_e state_q, state_d;
  logic [CC_W-1:0]       cc_q;
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [IDX_W-1:0]      fill_q, fill_d;
  logic                  wr_bank_q, wr_bank_d;
  logic [IDX_W:0]        emit_q, emit_d;
  logic [IDX_W-1:0]      k_q, k_d;
  logic [IDX_W-1:0]      n_q, n_d;
  logic [TW_IDX_W-1:0]   m_q, m_d, tw_step_q, tw_step_d;
  logic [SQRT_CNT_W-1:0] cnt_q, cnt_d;

  logic            accept, keep, frame_done, emit_go;
  logic [CC_W-1:0] cc_eff;
  logic [CC_W-1:0] phase_inc;

  assign accept     = start && (state_q == S_IDLE);
  assign keep       = (phase_q == '0);
  assign frame_done = keep && (fill_q == IDX_W'(POINTS - 1));
  assign emit_go    = frame_done || (emit_q < (IDX_W + 1)'(POINTS));

  // Clamp the channel count into its useful range
  always_comb begin
    if (cc_q == '0) begin
      cc_eff = CC_W'(1);
    end else if (cc_q > CC_W'(MAX_CHANNELS)) begin
      cc_eff = CC_W'(MAX_CHANNELS);
    end else begin
      cc_eff = cc_q;
    end
  end
  assign phase_inc = CC_W'(phase_q) + CC_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept && emit_go) state_d = S_MAC;
      S_MAC:    if (n_q == IDX_W'(POINTS - 1)) state_d = S_DRAIN;
      S_DRAIN:  if (!status_i.pipe_busy) state_d = S_ROUND;
      S_ROUND:  state_d = S_SQUARE;
      S_SQUARE: state_d = S_SUM;
      S_SUM:    state_d = S_SQRT;
      S_SQRT:   if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) state_d = S_OUT;
      S_OUT:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_en     = accept && keep;
    cmd_o.acc_clear = accept;
    cmd_o.mac_issue = (state_q == S_MAC);
    cmd_o.tw_idx    = m_q;
    cmd_o.do_round  = (state_q == S_ROUND);
    cmd_o.do_square = (state_q == S_SQUARE);
    cmd_o.do_sum    = (state_q == S_SUM);
    cmd_o.sqrt_step = (state_q == S_SQRT);
    wr_addr_o       = {wr_bank_q, fill_q};
    rd_addr_o       = {~wr_bank_q, n_q};
    busy            = (state_q != S_IDLE);
    result_valid_o  = (state_q == S_OUT);
    bin_index_o     = BIN_W'(k_q);
    last_bin_o      = (k_q == IDX_W'(POINTS - 1));
  end

  // Counters and frame bookkeeping
  always_comb begin
    phase_d   = phase_q;
    fill_d    = fill_q;
    wr_bank_d = wr_bank_q;
    emit_d    = emit_q;
    k_d       = k_q;
    n_d       = n_q;
    m_d       = m_q;
    tw_step_d = tw_step_q;
    cnt_d     = cnt_q;
    if (accept) begin
      phase_d = (phase_inc >= cc_eff) ? '0 : PHASE_W'(phase_inc);
      if (keep) begin
        fill_d = fill_q + IDX_W'(1);
        if (frame_done) begin
          wr_bank_d = ~wr_bank_q;
          emit_d    = '0;
        end
      end
      k_d       = frame_done ? '0 : emit_q[IDX_W-1:0];
      tw_step_d = TW_IDX_W'(k_d) * TW_IDX_W'(STRIDE);
      n_d       = '0;
      m_d       = '0;
    end
    if (state_q == S_MAC) begin
      n_d = n_q + IDX_W'(1);
      m_d = m_q + tw_step_q;
    end
    if (state_q == S_SUM) cnt_d = '0;
    if (state_q == S_SQRT) cnt_d = cnt_q + SQRT_CNT_W'(1);
    if (state_q == S_OUT) emit_d = emit_q + (IDX_W + 1)'(1);
  end

  // Hold state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cc_q      <= CC_W'(1);
      phase_q   <= '0;
      fill_q    <= '0;
      wr_bank_q <= 1'b0;
      emit_q    <= (IDX_W + 1)'(POINTS);
      k_q       <= '0;
      n_q       <= '0;
      m_q       <= '0;
      tw_step_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) cc_q <= cfg_wdata_i;
      phase_q   <= phase_d;
      fill_q    <= fill_d;
      wr_bank_q <= wr_bank_d;
      emit_q    <= emit_d;
      k_q       <= k_d;
      n_q       <= n_d;
      m_q       <= m_d;
      tw_step_q <= tw_step_d;
      cnt_q     <= cnt_d;
    end
  end

  `FMS_ASSERT(a_out_then_idle, clk_i, rst_ni, (state_q == S_OUT) |=> (state_q == S_IDLE), "result not followed by idle")
  `FMS_ASSERT_NEVER(a_emit_range, clk_i, rst_ni, emit_q > (IDX_W + 1)'(POINTS), "bin counter out of range")
  `FMS_ASSERT(a_mac_entry, clk_i, rst_ni, $rose(state_q == S_MAC) |-> (n_q == '0 && m_q == '0), "bin sweep not started at zero")
  `FMS_ASSERT_NEVER(a_drain_wait, clk_i, rst_ni, (state_q == S_ROUND) && status_i.pipe_busy, "rounding before accumulation settled")

endmodule

/* rtl/core/fms_datapath.sv */
// Datapath: sample memory, twiddle multiply-accumulate, rounding and square root.
module fms_datapath #(
  parameter int POINTS = 64,
  parameter int IDX_W  = $clog2(POINTS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fms_pkg::cmd_t                     cmd_i,
  output fms_pkg::status_t                  status_o,
  input  logic [IDX_W:0]                    wr_addr_i,
  input  logic [IDX_W:0]                    rd_addr_i,
  input  logic signed [fms_pkg::SAMPLE_W-1:0] sample_i,
  output logic [fms_pkg::MAG_W-1:0]         magnitude_o
);
  import fms_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 << (TW_FRAC - 1));

  // Two sample banks: one fills while the other is transformed
  logic signed [SAMPLE_W-1:0] mem_q [2*POINTS];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic signed [TW_W-1:0]     cos_q, sin_q;
  logic                       v1_q, v2_q;
  logic signed [PROD_W-1:0]   pre_q, pim_q, pre_d, pim_d;
  logic signed [ACC_W-1:0]    re_acc_q, im_acc_q, re_sum, im_sum;
  logic signed [RND_W-1:0]    re_rnd_q, im_rnd_q;
  logic signed [2*RND_W-1:0]  re_sq, im_sq;
  logic [RAD_W-1:0]           sq_re_q, sq_im_q, rad_q, res_q, bit_q, trial;

  // Write kept samples, read the completed bank
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[wr_addr_i] <= sample_i;
    rd_q  <= mem_q[rd_addr_i];
    cos_q <= cos64(cmd_i.tw_idx);
    sin_q <= sin64(cmd_i.tw_idx);
  end

  // Track data in flight through the multiply pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end
  assign status_o.pipe_busy = v1_q || v2_q;

  assign pre_d = rd_q * cos_q;
  assign pim_d = rd_q * sin_q;
  assign re_sum = re_acc_q + HALF;
  assign im_sum = im_acc_q + HALF;
  assign re_sq  = re_rnd_q * re_rnd_q;
  assign im_sq  = im_rnd_q * im_rnd_q;
  assign trial  = res_q + bit_q;

  // Multiply, accumulate, round, square and take the floor square root
  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
    pim_q <= pim_d;
    if (cmd_i.acc_clear) begin
      re_acc_q <= '0;
      im_acc_q <= '0;
    end else if (v2_q) begin
      re_acc_q <= re_acc_q + ACC_W'(pre_q);
      im_acc_q <= im_acc_q - ACC_W'(pim_q);
    end
    if (cmd_i.do_round) begin
      re_rnd_q <= RND_W'(re_sum >>> TW_FRAC);
      im_rnd_q <= RND_W'(im_sum >>> TW_FRAC);
    end
    if (cmd_i.do_square) begin
      sq_re_q <= RAD_W'(re_sq);
      sq_im_q <= RAD_W'(im_sq);
    end
    if (cmd_i.do_sum) begin
      rad_q <= sq_re_q + sq_im_q;
      res_q <= '0;
      bit_q <= RAD_W'(1) << (RAD_W - 2);
    end else if (cmd_i.sqrt_step) begin
      if (rad_q >= trial) begin
        rad_q <= rad_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign magnitude_o = res_q[MAG_W-1:0];

endmodule

/* rtl/core/fft_magnitude_spectrum.sv */
// Top level of the single-channel magnitude spectrum block.
// Usage:
//  - Pulse start with sample_i while busy is low; that edge accepts the transaction.
//  - Only channel 0 of each interleaved frame of channel_count samples is kept
//    (cfg_we_i/cfg_wdata_i write the count; 0 acts as 1, above 8 as 8).
//  - When POINTS kept samples are held, each accepted sample from then on
//    yields one bin magnitude, bins 0 to POINTS-1 in turn, while the next
//    frame keeps filling the other sample bank.
//  - A sample that yields no bin is taken and busy stays low.
//  - A sample that yields a bin keeps busy high through a twiddle
//    multiply-accumulate over all POINTS samples through the sample memory
//    read port, pipeline drain, rounding, squaring, summing and a
//    22-step square root, then the output cycle.
//    result_valid_o is high in that last busy cycle with magnitude_o, bin_index_o
//    and last_bin_o; the receiver cannot stall and must take it then.
//  - Reset clears the fill count and channel phase, leaves no bins pending
//    until a frame completes, and returns the channel count to 1.
module fft_magnitude_spectrum #(
  parameter int POINTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [fms_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                               cfg_we_i,
  input  logic [fms_pkg::CC_W-1:0]           cfg_wdata_i,
  output logic                               result_valid_o,
  output logic [fms_pkg::MAG_W-1:0]          magnitude_o,
  output logic [fms_pkg::BIN_W-1:0]          bin_index_o,
  output logic                               last_bin_o
);
  import fms_pkg::*;

  localparam int IDX_W = $clog2(POINTS);

  cmd_t           cmd;
  status_t        status;
  logic [IDX_W:0] wr_addr, rd_addr;

  // Sequence frames and bins
  fms_ctrl #(.POINTS(POINTS), .IDX_W(IDX_W)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_o          (cmd),
    .status_i       (status),
    .wr_addr_o      (wr_addr),
    .rd_addr_o      (rd_addr),
    .result_valid_o (result_valid_o),
    .bin_index_o    (bin_index_o),
    .last_bin_o     (last_bin_o)
  );

  // Compute each bin magnitude
  fms_datapath #(.POINTS(POINTS), .IDX_W(IDX_W)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .wr_addr_i   (wr_addr),
    .rd_addr_i   (rd_addr),
    .sample_i    (sample_i),
    .magnitude_o (magnitude_o)
  );

endmodule
